[src/shps_pkg.sv]
package shps_pkg;

  typedef enum logic [4:0] {
    PH_DORMANT, PH_SYNC, PH_INIT, PH_RUN, PH_FAULT, PH_CBEGIN,
    PH_C0, PH_C1, PH_C2, PH_C3, PH_C4, PH_C5, PH_C6, PH_C7, PH_C8, PH_C9,
    PH_C10, PH_C11
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_WAIT, ST_CHECK, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_CALIB   = 3'd2,
    CMD_START   = 3'd3,
    CMD_RELEASE = 3'd4,
    CMD_STOP    = 3'd5
  } item_cmd_t;

  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_SKIP  = 2'd1,
    KIND_COAST = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_UNCAL     = 3'd1,
    ERR_LIMIT     = 3'd2,
    ERR_CAL_FAIL  = 3'd3,
    ERR_BAD_STATE = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    MODE_DORMANT = 3'd0,
    MODE_SYNC    = 3'd1,
    MODE_RUN     = 3'd2,
    MODE_CALIB   = 3'd3,
    MODE_FAULT   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_FLIP       = 3'd0,
    REG_START_POS  = 3'd1,
    REG_COAST      = 3'd2,
    REG_CAL_DELAY  = 3'd3,
    REG_MAX_TRAVEL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic start_scan;
    logic advance;
    logic finish;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_table;
    logic skip_more;
  } ctl_stat_t;

endpackage

[src/shps_ctrl.sv]
module shps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  shps_pkg::ctl_stat_t stat,
  output shps_pkg::ctl_cmd_t  ctl
);

  shps_pkg::ctrl_state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shps_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      shps_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
        if (in_valid) state_next = shps_pkg::ST_DECIDE;
      end
      shps_pkg::ST_DECIDE: begin
        if (stat.need_table) begin
          ctl.start_scan = 1'b1;
          state_next     = shps_pkg::ST_WAIT;
        end else begin
          ctl.exec   = 1'b1;
          state_next = shps_pkg::ST_EMIT;
        end
      end
      shps_pkg::ST_WAIT: state_next = shps_pkg::ST_CHECK;
      shps_pkg::ST_CHECK: begin
        if (stat.skip_more) begin
          ctl.advance = 1'b1;
          state_next  = shps_pkg::ST_WAIT;
        end else begin
          ctl.finish = 1'b1;
          state_next = shps_pkg::ST_EMIT;
        end
      end
      shps_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          ctl.emit   = 1'b1;
          state_next = shps_pkg::ST_IDLE;
        end
      end
      default: state_next = shps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.emit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

[src/shps_dpath.sv]
module shps_dpath #(
  parameter int NUM_PROFILES      = 4,
  parameter int SLOTS_PER_PROFILE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  shps_pkg::ctl_cmd_t  ctl,
  output shps_pkg::ctl_stat_t stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [2:0]          cmd,
  input  logic                left_limit,
  input  logic                right_limit,
  input  logic [1:0]          profile_sel,
  input  logic [3:0]          entry_index,
  input  logic [1:0]          entry_kind,
  input  logic [15:0]         entry_steps,
  input  logic [15:0]         entry_delay,
  input  logic                move_dir,
  input  logic                sync_hold,
  output logic                step_pulse,
  output logic                dir_level,
  output logic signed [23:0]  position,
  output logic [15:0]         travel_span,
  output logic                is_calibrated,
  output logic [2:0]          mode,
  output logic [2:0]          error_code
);

  localparam int DEPTH = NUM_PROFILES * SLOTS_PER_PROFILE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(SLOTS_PER_PROFILE);

  // configuration
  logic        flip;
  logic [15:0] start_pos, coast, max_travel;
  logic [7:0]  cal_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      flip       <= 1'b0;
      start_pos  <= '0;
      coast      <= '0;
      cal_delay  <= 8'd2;
      max_travel <= 16'd4000;
    end else if (cfg_we) begin
      case (cfg_index)
        shps_pkg::REG_FLIP:       flip       <= cfg_data[0];
        shps_pkg::REG_START_POS:  start_pos  <= cfg_data;
        shps_pkg::REG_COAST:      coast      <= cfg_data;
        shps_pkg::REG_CAL_DELAY:  cal_delay  <= cfg_data[7:0];
        shps_pkg::REG_MAX_TRAVEL: max_travel <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched word
  logic [2:0]  c_cmd;
  logic        c_left, c_right, c_dir, c_sync;
  logic [1:0]  c_psel, c_kind;
  logic [3:0]  c_idx;
  logic [15:0] c_steps, c_delay;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      c_cmd   <= cmd;
      c_left  <= left_limit;
      c_right <= right_limit;
      c_psel  <= profile_sel;
      c_idx   <= entry_index;
      c_kind  <= entry_kind;
      c_steps <= entry_steps;
      c_delay <= entry_delay;
      c_dir   <= move_dir;
      c_sync  <= sync_hold;
    end
  end

  // sequencer state
  shps_pkg::phase_t    phase, phase_next;
  shps_pkg::err_t      err, err_next;
  logic                dir_st, dir_st_next, cal, cal_next, pulse, pulse_next;
  logic [23:0]         pos, pos_next;
  logic [15:0]         span, span_next, dly, dly_next, steps, steps_next;
  logic [SW-1:0]       slot, slot_next;
  logic [1:0]          aprof, aprof_next;
  logic signed [17:0]  trav, trav_next;
  logic [SW:0]         scan, scan_next;
  logic                bmode, bmode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= shps_pkg::PH_DORMANT;
      err    <= shps_pkg::ERR_OK;
      dir_st <= 1'b0;
      cal    <= 1'b0;
      pulse  <= 1'b0;
      pos    <= '0;
      span   <= '0;
      dly    <= '0;
      steps  <= '0;
      slot   <= '0;
      aprof  <= '0;
      trav   <= '0;
      scan   <= '0;
      bmode  <= 1'b0;
    end else begin
      phase  <= phase_next;
      err    <= err_next;
      dir_st <= dir_st_next;
      cal    <= cal_next;
      pulse  <= pulse_next;
      pos    <= pos_next;
      span   <= span_next;
      dly    <= dly_next;
      steps  <= steps_next;
      slot   <= slot_next;
      aprof  <= aprof_next;
      trav   <= trav_next;
      scan   <= scan_next;
      bmode  <= bmode_next;
    end
  end

  // profile table: {kind, steps, delay}
  logic [33:0]   table_mem [DEPTH];
  logic [33:0]   rd_data;
  logic [SW:0]   rd_scan, scan_start;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en;
  logic [1:0]    rd_kind;
  logic [15:0]   rd_steps, rd_delay;

  assign rd_kind  = rd_data[33:32];
  assign rd_steps = rd_data[31:16];
  assign rd_delay = rd_data[15:0];

  assign scan_start = (phase == shps_pkg::PH_INIT || steps != 16'd0)
                    ? (SW+1)'(slot) : (SW+1)'(slot) + (SW+1)'(1);
  assign rd_scan = ctl.start_scan ? scan_start : scan + (SW+1)'(1);
  assign rd_en   = (ctl.start_scan || ctl.advance) && (rd_scan < (SW+1)'(SLOTS_PER_PROFILE));
  assign rd_addr = AW'(AW'(aprof) * AW'(SLOTS_PER_PROFILE) + AW'(rd_scan[SW-1:0]));
  assign wr_en   = ctl.exec && (c_cmd == shps_pkg::CMD_LOAD)
                 && (32'(c_psel) < NUM_PROFILES) && (32'(c_idx) < SLOTS_PER_PROFILE);
  assign wr_addr = AW'(AW'(c_psel) * AW'(SLOTS_PER_PROFILE) + AW'(c_idx));

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= {c_kind, c_steps, c_delay};
    if (rd_en) rd_data <= table_mem[rd_addr];
  end

  logic scan_in;
  assign scan_in = scan < (SW+1)'(SLOTS_PER_PROFILE);

  assign stat.need_table = (c_cmd == shps_pkg::CMD_TICK) && cal
                         && (phase == shps_pkg::PH_INIT
                             || (phase == shps_pkg::PH_RUN && dly == 16'd0));
  assign stat.skip_more  = bmode && scan_in && (rd_kind == shps_pkg::KIND_SKIP);

  logic signed [17:0] trav_dec;
  logic [15:0]        dly_dec, st_steps;
  assign trav_dec = trav - 18'sd1;
  assign dly_dec  = (dly != 16'd0) ? dly - 16'd1 : 16'd0;
  assign st_steps = !bmode ? steps
                  : (rd_kind == shps_pkg::KIND_COAST) ? coast : rd_steps;

  always_comb begin
    phase_next  = phase;
    err_next    = err;
    dir_st_next = dir_st;
    cal_next    = cal;
    pulse_next  = pulse;
    pos_next    = pos;
    span_next   = span;
    dly_next    = dly;
    steps_next  = steps;
    slot_next   = slot;
    aprof_next  = aprof;
    trav_next   = trav;
    scan_next   = scan;
    bmode_next  = bmode;

    if (ctl.start_scan) begin
      pulse_next = 1'b0;
      scan_next  = scan_start;
      bmode_next = !(phase == shps_pkg::PH_RUN && steps != 16'd0);
    end
    if (ctl.advance) scan_next = rd_scan;

    if (ctl.finish) begin
      if (bmode && (!scan_in || rd_kind == shps_pkg::KIND_END)) begin
        phase_next = shps_pkg::PH_DORMANT;
      end else begin
        if (bmode) slot_next = scan[SW-1:0];
        steps_next = st_steps;
        if (phase == shps_pkg::PH_INIT) begin
          phase_next = shps_pkg::PH_RUN;
        end else if (c_left || c_right) begin
          phase_next = shps_pkg::PH_FAULT;
          err_next   = shps_pkg::ERR_LIMIT;
        end else begin
          dly_next   = rd_delay;
          pulse_next = 1'b1;
          pos_next   = (dir_st == 1'b0) ? pos + 24'd1 : pos - 24'd1;
          steps_next = (st_steps != 16'd0) ? st_steps - 16'd1 : 16'd0;
        end
      end
    end

    if (ctl.exec) begin
      pulse_next = 1'b0;
      case (c_cmd)
        shps_pkg::CMD_TICK: begin
          case (phase)
            shps_pkg::PH_INIT: err_next = shps_pkg::ERR_UNCAL;
            shps_pkg::PH_RUN: begin
              if (!cal) err_next = shps_pkg::ERR_UNCAL;
              else dly_next = dly - 16'd1;
            end
            shps_pkg::PH_CBEGIN: begin
              trav_next   = 18'($signed({2'b00, max_travel}));
              dir_st_next = 1'b0;
              phase_next  = shps_pkg::PH_C0;
            end
            shps_pkg::PH_C0: begin
              if (c_left) begin
                pulse_next = 1'b1;
                trav_next  = trav_dec;
                if (trav_dec <= 18'sd0) begin
                  err_next   = shps_pkg::ERR_CAL_FAIL;
                  phase_next = shps_pkg::PH_DORMANT;
                end
              end else begin
                dir_st_next = 1'b1;
                phase_next  = shps_pkg::PH_C1;
              end
            end
            shps_pkg::PH_C1: begin
              pulse_next = 1'b1;
              if (cal_delay != 8'd0) begin
                dly_next   = {8'd0, cal_delay};
                phase_next = shps_pkg::PH_C2;
              end else phase_next = shps_pkg::PH_C3;
            end
            shps_pkg::PH_C2: begin
              dly_next = dly_dec;
              if (dly_dec == 16'd0) phase_next = shps_pkg::PH_C3;
            end
            shps_pkg::PH_C3: begin
              if (c_left) begin
                pos_next    = '0;
                trav_next   = 18'($signed({2'b00, max_travel}));
                dir_st_next = 1'b0;
                phase_next  = shps_pkg::PH_C4;
              end else phase_next = shps_pkg::PH_C1;
            end
            shps_pkg::PH_C4: begin
              pulse_next = 1'b1;
              pos_next   = pos + 24'd1;
              trav_next  = trav_dec;
              if (trav_dec <= 18'sd0) begin
                err_next   = shps_pkg::ERR_CAL_FAIL;
                phase_next = shps_pkg::PH_DORMANT;
              end else if (cal_delay != 8'd0) begin
                dly_next   = {8'd0, cal_delay};
                phase_next = shps_pkg::PH_C5;
              end else phase_next = shps_pkg::PH_C6;
            end
            shps_pkg::PH_C5: begin
              dly_next = dly_dec;
              if (dly_dec == 16'd0) phase_next = shps_pkg::PH_C6;
            end
            shps_pkg::PH_C6: phase_next = c_right ? shps_pkg::PH_C7 : shps_pkg::PH_C4;
            shps_pkg::PH_C7: begin
              span_next   = pos[15:0];
              cal_next    = 1'b1;
              dir_st_next = 1'b1;
              trav_next   = $signed({2'b00, pos[15:0]}) - $signed({2'b00, start_pos});
              phase_next  = shps_pkg::PH_C8;
            end
            shps_pkg::PH_C8: begin
              pulse_next = 1'b1;
              pos_next   = pos - 24'd1;
              trav_next  = trav_dec;
              if (trav_dec <= 18'sd0) begin
                err_next   = shps_pkg::ERR_OK;
                phase_next = shps_pkg::PH_DORMANT;
              end else if (cal_delay != 8'd0) begin
                dly_next   = {8'd0, cal_delay};
                phase_next = shps_pkg::PH_C9;
              end else phase_next = shps_pkg::PH_C10;
            end
            shps_pkg::PH_C9: begin
              dly_next = dly_dec;
              if (dly_dec == 16'd0) phase_next = shps_pkg::PH_C10;
            end
            shps_pkg::PH_C10: phase_next = (trav == 18'sd0) ? shps_pkg::PH_C11
                                                            : shps_pkg::PH_C8;
            shps_pkg::PH_C11: begin
              err_next   = shps_pkg::ERR_OK;
              phase_next = shps_pkg::PH_DORMANT;
            end
            default: ;
          endcase
        end
        shps_pkg::CMD_CALIB: begin
          if (phase == shps_pkg::PH_DORMANT || phase == shps_pkg::PH_FAULT) begin
            phase_next = shps_pkg::PH_CBEGIN;
            err_next   = shps_pkg::ERR_OK;
          end else err_next = shps_pkg::ERR_BAD_STATE;
        end
        shps_pkg::CMD_START: begin
          if (phase == shps_pkg::PH_DORMANT && 32'(c_psel) < NUM_PROFILES) begin
            aprof_next  = c_psel;
            slot_next   = '0;
            dir_st_next = c_dir;
            dly_next    = '0;
            steps_next  = '0;
            err_next    = shps_pkg::ERR_OK;
            phase_next  = c_sync ? shps_pkg::PH_SYNC : shps_pkg::PH_INIT;
          end else err_next = shps_pkg::ERR_BAD_STATE;
        end
        shps_pkg::CMD_RELEASE: begin
          if (phase == shps_pkg::PH_SYNC) phase_next = shps_pkg::PH_INIT;
        end
        shps_pkg::CMD_STOP: phase_next = shps_pkg::PH_DORMANT;
        default: ;
      endcase
    end
  end

  shps_pkg::mode_t mode_cur;
  always_comb begin
    case (phase)
      shps_pkg::PH_DORMANT: mode_cur = shps_pkg::MODE_DORMANT;
      shps_pkg::PH_SYNC:    mode_cur = shps_pkg::MODE_SYNC;
      shps_pkg::PH_INIT,
      shps_pkg::PH_RUN:     mode_cur = shps_pkg::MODE_RUN;
      shps_pkg::PH_FAULT:   mode_cur = shps_pkg::MODE_FAULT;
      default:              mode_cur = shps_pkg::MODE_CALIB;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      step_pulse    <= pulse;
      dir_level     <= dir_st ^ flip;
      position      <= $signed(pos);
      travel_span   <= span;
      is_calibrated <= cal;
      mode          <= mode_cur;
      error_code    <= err;
    end
  end

endmodule

[src/stepper_homing_and_profile_sequencer_unit.sv]
// channel  signals                                    accepted when
// in       in_valid/in_ready, cmd .. sync_hold        in_valid && in_ready
// out      out_valid/out_ready, step_pulse .. error   out_valid && out_ready
// cfg      cfg_we, cfg_index, cfg_data                cfg_we
// An accepted word is latched, then executed before its result is emitted; a
// running tick that reads the profile table instead examines one slot at a time
// through the single table read port, up to a whole profile when skipping slots.
// Synchronous active-high reset; the table is not cleared.
// A stalled result holds in the output register; the next word is taken
// as soon as the previous result is loaded there.
module stepper_homing_and_profile_sequencer_unit #(
  parameter int NUM_PROFILES      = 4,
  parameter int SLOTS_PER_PROFILE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic               left_limit,
  input  logic               right_limit,
  input  logic [1:0]         profile_sel,
  input  logic [3:0]         entry_index,
  input  logic [1:0]         entry_kind,
  input  logic [15:0]        entry_steps,
  input  logic [15:0]        entry_delay,
  input  logic               move_dir,
  input  logic               sync_hold,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               step_pulse,
  output logic               dir_level,
  output logic signed [23:0] position,
  output logic [15:0]        travel_span,
  output logic               is_calibrated,
  output logic [2:0]         mode,
  output logic [2:0]         error_code,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  shps_pkg::ctl_cmd_t  ctl;
  shps_pkg::ctl_stat_t stat;

  shps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  shps_dpath #(
    .NUM_PROFILES      (NUM_PROFILES),
    .SLOTS_PER_PROFILE (SLOTS_PER_PROFILE)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .left_limit    (left_limit),
    .right_limit   (right_limit),
    .profile_sel   (profile_sel),
    .entry_index   (entry_index),
    .entry_kind    (entry_kind),
    .entry_steps   (entry_steps),
    .entry_delay   (entry_delay),
    .move_dir      (move_dir),
    .sync_hold     (sync_hold),
    .step_pulse    (step_pulse),
    .dir_level     (dir_level),
    .position      (position),
    .travel_span   (travel_span),
    .is_calibrated (is_calibrated),
    .mode          (mode),
    .error_code    (error_code)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second word right after the first");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(mode)
                                && $stable(error_code) && $stable(step_pulse))
    else $error("stalled result changed before it was taken");

  a_no_step_in_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_pulse |-> mode != shps_pkg::MODE_FAULT)
    else $error("step pulse reported with fault mode");
`endif

endmodule
